### rtl/irfc_pkg.sv
package irfc_pkg;

    localparam int DEF_TRIG_ITERATIONS = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 6;
    localparam int MAX_TRIG_ITERATIONS = 24;

    localparam int RATE_W   = 16;
    localparam int RATE_C_W = 17;
    localparam int ANG_W    = 15;
    localparam int OUT_W    = 17;
    localparam int Q15_W    = 16;
    localparam int XY_W     = 34;
    localparam int Z_W      = 29;
    localparam int ANG_SHIFT = 20;

    localparam logic signed [XY_W-1:0] CORDIC_INIT = 34'sd652032875;

    // register index codes (decoded from paddr[2])
    localparam logic REG_YAW_OFFSET   = 1'b0;
    localparam logic REG_PITCH_OFFSET = 1'b1;

    typedef struct packed {
        logic signed [RATE_C_W-1:0] yc;
        logic signed [RATE_C_W-1:0] pc;
        logic signed [RATE_W-1:0]   rr;
        logic signed [ANG_W-1:0]    roll;
    } t_item;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
    } t_rot;

    typedef struct packed {
        t_item item;
        t_rot  pitch;
        t_rot  roll;
    } t_cell_word;

    // arctangent of 2^-i in 2^-20 degree
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
        case (idx)
            5'd0:  return 29'sd47185920;
            5'd1:  return 29'sd27855475;
            5'd2:  return 29'sd14718068;
            5'd3:  return 29'sd7471121;
            5'd4:  return 29'sd3750058;
            5'd5:  return 29'sd1876857;
            5'd6:  return 29'sd938658;
            5'd7:  return 29'sd469357;
            5'd8:  return 29'sd234682;
            5'd9:  return 29'sd117342;
            5'd10: return 29'sd58671;
            5'd11: return 29'sd29335;
            5'd12: return 29'sd14668;
            5'd13: return 29'sd7334;
            5'd14: return 29'sd3667;
            5'd15: return 29'sd1833;
            5'd16: return 29'sd917;
            5'd17: return 29'sd458;
            5'd18: return 29'sd229;
            5'd19: return 29'sd115;
            5'd20: return 29'sd57;
            5'd21: return 29'sd29;
            5'd22: return 29'sd14;
            5'd23: return 29'sd7;
            default: return 29'sd0;
        endcase
    endfunction

endpackage

### rtl/irfc_in_if.sv
interface irfc_in_if;
    import irfc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] yaw_rate_in;
    logic signed [RATE_W-1:0] pitch_rate_in;
    logic signed [RATE_W-1:0] roll_rate_in;
    logic signed [ANG_W-1:0]  roll_angle_in;
    logic signed [ANG_W-1:0]  pitch_angle_in;

    modport source(output valid, yaw_rate_in, pitch_rate_in, roll_rate_in,
                   roll_angle_in, pitch_angle_in, input ready);
    modport sink(input valid, yaw_rate_in, pitch_rate_in, roll_rate_in,
                 roll_angle_in, pitch_angle_in, output ready);
endinterface

### rtl/irfc_out_if.sv
interface irfc_out_if;
    import irfc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] yaw_rate_out;
    logic signed [OUT_W-1:0] pitch_rate_out;
    logic signed [ANG_W-1:0] roll_angle_out;

    modport source(output valid, yaw_rate_out, pitch_rate_out, roll_angle_out,
                   input ready);
    modport sink(input valid, yaw_rate_out, pitch_rate_out, roll_angle_out,
                 output ready);
endinterface

### rtl/irfc_prep.sv
module irfc_prep #(
    parameter int ANGLE_FRAC_BITS = irfc_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    irfc_in_if.sink                             i_in,
    input  logic signed [irfc_pkg::RATE_W-1:0]  i_yaw_off,
    input  logic signed [irfc_pkg::RATE_W-1:0]  i_pitch_off,
    output logic                                o_valid,
    input  logic                                i_ready,
    output irfc_pkg::t_cell_word                o_word
);
    import irfc_pkg::*;

    localparam int AW = 18;
    localparam logic signed [AW-1:0] BAND = AW'(5 << ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] FLIP = AW'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [AW:0]   DEG_BIAS = 19'sd92160;
    localparam logic [AW-1:0]        RECIP = 18'd186414;
    localparam logic signed [18:0]   FULL    = 19'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [18:0]   HALF    = 19'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [18:0]   QUARTER = 19'(90 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic [AW-1:0] dp;
        logic [7:0]    frac;
    } t_split;

    logic   r1_v, r2_v, r3_v;
    logic   rdy1, rdy2, rdy3;
    t_item  r1_item, r2_item, n1_item;
    t_split r1_p, r1_r, r2_p, r2_r, n1_p, n1_r;
    logic [9:0] r2_qp, r2_qr, n2_qp, n2_qr;
    t_cell_word r3_word, n3_word;

    // whole degrees biased positive by a multiple of 360, plus fraction
    function automatic t_split split_ang(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] d;
        logic signed [AW-1:0] f;
        t_split s;
        d = a >>> ANGLE_FRAC_BITS;
        f = a - (d <<< ANGLE_FRAC_BITS);
        s.dp = AW'((AW+1)'(d) + DEG_BIAS);
        s.frac = f[7:0];
        return s;
    endfunction

    function automatic logic [9:0] quot360(input logic [AW-1:0] dp);
        logic [2*AW-1:0] prod;
        prod = (2*AW)'(dp) * (2*AW)'(RECIP);
        return prod[2*AW-1:26];
    endfunction

    function automatic t_rot reduce(input t_split s, input logic [9:0] q);
        logic [AW-1:0]      rem;
        logic signed [18:0] zd;
        t_rot               r;
        rem = s.dp - AW'(q) * AW'(360);
        zd = (19'(rem[8:0]) <<< ANGLE_FRAC_BITS) + 19'(s.frac);
        r.neg = 1'b0;
        if (zd > HALF) zd = zd - FULL;
        if (zd > QUARTER) begin
            zd = zd - HALF;
            r.neg = 1'b1;
        end else if (zd < -QUARTER) begin
            zd = zd + HALF;
            r.neg = 1'b1;
        end
        r.z = Z_W'(zd) <<< (ANG_SHIFT - ANGLE_FRAC_BITS);
        r.x = CORDIC_INIT;
        r.y = '0;
        return r;
    endfunction

    assign rdy3 = !r3_v || i_ready;
    assign rdy2 = !r2_v || rdy3;
    assign rdy1 = !r1_v || rdy2;
    assign i_in.ready = rdy1;

    always_comb begin
        logic signed [AW-1:0] roll_s;
        roll_s = AW'(i_in.roll_angle_in);
        if (!(roll_s > -BAND && roll_s < BAND)) begin
            roll_s = (roll_s > 0) ? roll_s - FLIP : roll_s + FLIP;
        end
        n1_item.yc = RATE_C_W'(i_in.yaw_rate_in) - RATE_C_W'(i_yaw_off);
        n1_item.pc = RATE_C_W'(i_in.pitch_rate_in) - RATE_C_W'(i_pitch_off);
        n1_item.rr = i_in.roll_rate_in;
        n1_item.roll = roll_s[ANG_W-1:0];
        n1_r = split_ang(roll_s);
        n1_p = split_ang(AW'(i_in.pitch_angle_in));
    end

    assign n2_qp = quot360(r1_p.dp);
    assign n2_qr = quot360(r1_r.dp);

    always_comb begin
        n3_word.item  = r2_item;
        n3_word.pitch = reduce(r2_p, r2_qp);
        n3_word.roll  = reduce(r2_r, r2_qr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_in.valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in.valid) begin
            r1_item <= n1_item;
            r1_p <= n1_p;
            r1_r <= n1_r;
        end
        if (rdy2 && r1_v) begin
            r2_item <= r1_item;
            r2_p <= r1_p;
            r2_r <= r1_r;
            r2_qp <= n2_qp;
            r2_qr <= n2_qr;
        end
        if (rdy3 && r2_v) r3_word <= n3_word;
    end

    assign o_valid = r3_v;
    assign o_word = r3_word;

endmodule

### rtl/irfc_cell.sv
module irfc_cell #(
    parameter int ITER = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  irfc_pkg::t_cell_word i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output irfc_pkg::t_cell_word o_word
);
    import irfc_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_lut(5'(ITER));

    logic       r_valid;
    t_cell_word r_word, n_word;

    // one micro-rotation; zero residual counts as positive
    function automatic t_rot step(input t_rot a);
        t_rot r;
        r = a;
        if (a.z >= 0) begin
            r.x = a.x - (a.y >>> ITER);
            r.y = a.y + (a.x >>> ITER);
            r.z = a.z - ATAN;
        end else begin
            r.x = a.x + (a.y >>> ITER);
            r.y = a.y - (a.x >>> ITER);
            r.z = a.z + ATAN;
        end
        return r;
    endfunction

    always_comb begin
        n_word.item  = i_word.item;
        n_word.pitch = step(i_word.pitch);
        n_word.roll  = step(i_word.roll);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word = r_word;

endmodule

### rtl/irfc_post.sv
module irfc_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  irfc_pkg::t_cell_word i_word,
    irfc_out_if.source           o_out
);
    import irfc_pkg::*;

    localparam int PW = RATE_C_W + Q15_W;

    logic r1_v, r2_v, r3_v;
    logic rdy1, rdy2, rdy3;
    t_item r1_item;
    logic signed [Q15_W-1:0] r1_cp, r1_sp, r1_cr, r1_sr;
    logic signed [PW-1:0] r2_p0, r2_p1, r2_p2, r2_p3;
    logic signed [ANG_W-1:0] r2_roll;
    logic signed [OUT_W-1:0] r3_yaw, r3_pitch, n3_yaw, n3_pitch;
    logic signed [ANG_W-1:0] r3_roll;

    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [XY_W-1:0] v,
                                                        input logic neg);
        logic signed [XY_W-1:0] s;
        logic signed [XY_W-1:0] t;
        s = neg ? -v : v;
        t = (s + 34'sd16384) >>> 15;
        if (t > 34'sd32767) return 16'sh7fff;
        if (t < -34'sd32768) return 16'sh8000;
        return t[Q15_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PW:0] acc);
        logic signed [PW:0] t;
        t = (acc + (PW+1)'(16384)) >>> 15;
        if (t > (PW+1)'(65535)) return 17'sh0ffff;
        if (t < -(PW+1)'(65536)) return 17'sh10000;
        return t[OUT_W-1:0];
    endfunction

    assign rdy3 = !r3_v || o_out.ready;
    assign rdy2 = !r2_v || rdy3;
    assign rdy1 = !r1_v || rdy2;
    assign o_ready = rdy1;

    assign n3_yaw   = round_sat((PW+1)'(r2_p0) + (PW+1)'(r2_p1));
    assign n3_pitch = round_sat((PW+1)'(r2_p3) - (PW+1)'(r2_p2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_item <= i_word.item;
            r1_cp <= to_q15(i_word.pitch.x, i_word.pitch.neg);
            r1_sp <= to_q15(i_word.pitch.y, i_word.pitch.neg);
            r1_cr <= to_q15(i_word.roll.x, i_word.roll.neg);
            r1_sr <= to_q15(i_word.roll.y, i_word.roll.neg);
        end
        if (rdy2 && r1_v) begin
            r2_p0 <= PW'(r1_item.yc) * PW'(r1_cp);
            r2_p1 <= PW'(r1_item.rr) * PW'(r1_sp);
            r2_p2 <= PW'(r1_item.pc) * PW'(r1_cr);
            r2_p3 <= PW'(r1_item.yc) * PW'(r1_sr);
            r2_roll <= r1_item.roll;
        end
        if (rdy3 && r2_v) begin
            r3_yaw <= n3_yaw;
            r3_pitch <= n3_pitch;
            r3_roll <= r2_roll;
        end
    end

    assign o_out.valid = r3_v;
    assign o_out.yaw_rate_out = r3_yaw;
    assign o_out.pitch_rate_out = r3_pitch;
    assign o_out.roll_angle_out = r3_roll;

endmodule

### rtl/imu_rate_frame_correction.sv
// channel   dir  handshake     word
// i_in      in   valid/ready   yaw, pitch, roll rate; roll, pitch angle
// o_out     out  valid/ready   compensated yaw and pitch rate, corrected roll
// apb       in   psel/penable  yaw and pitch rate offsets at 0x0 and 0x4
//
// One word enters per cycle while some stage is empty or the output is taken; the
// path is the CORDIC cell chain plus three prep and three output stages.
// Synchronous active-low reset empties every stage and zeroes the offsets.
// Every stage holds its word only while the stage after it is full and
// stalled, so bubbles collapse and the input stays open while the output
// register waits to be taken, until every stage holds a word.
module imu_rate_frame_correction #(
    parameter int TRIG_ITERATIONS = irfc_pkg::DEF_TRIG_ITERATIONS,
    parameter int ANGLE_FRAC_BITS = irfc_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    irfc_in_if.sink     i_in,
    irfc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import irfc_pkg::*;

    localparam int N = TRIG_ITERATIONS;

    logic signed [RATE_W-1:0] r_yaw_off, r_pitch_off;
    logic       cfg_wr;

    // handshake wires along the cell chain: index k feeds cell k
    logic       chain_v [N+1];
    logic       chain_r [N+1];
    t_cell_word chain_w [N+1];

    // configuration: write in the access phase, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_off <= '0;
            r_pitch_off <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_YAW_OFFSET:   r_yaw_off <= pwdata[RATE_W-1:0];
                REG_PITCH_OFFSET: r_pitch_off <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_YAW_OFFSET:   prdata = 32'(r_yaw_off);
            REG_PITCH_OFFSET: prdata = 32'(r_pitch_off);
            default:          prdata = '0;
        endcase
    end

    // offset removal, roll flip and angle range reduction
    irfc_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_yaw_off   (r_yaw_off),
        .i_pitch_off (r_pitch_off),
        .o_valid     (chain_v[0]),
        .i_ready     (chain_r[0]),
        .o_word      (chain_w[0])
    );

    // one CORDIC micro-rotation per cell, pitch and roll side by side
    for (genvar k = 0; k < N; k++) begin : g_cell
        irfc_cell #(.ITER(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_v[k]),
            .o_ready (chain_r[k]),
            .i_word  (chain_w[k]),
            .o_valid (chain_v[k+1]),
            .i_ready (chain_r[k+1]),
            .o_word  (chain_w[k+1])
        );
    end

    // Q1.15 conversion, products, round and saturate
    irfc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_v[N]),
        .o_ready (chain_r[N]),
        .i_word  (chain_w[N]),
        .o_out   (o_out)
    );

    a_yaw_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && paddr[2] == REG_YAW_OFFSET |=> r_yaw_off == $past(pwdata[RATE_W-1:0]))
        else $error("yaw offset write lost");

    a_pitch_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && paddr[2] == REG_PITCH_OFFSET
        |=> r_pitch_off == $past(pwdata[RATE_W-1:0]))
        else $error("pitch offset write lost");

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out.valid || o_out.ready) |-> i_in.ready)
        else $error("input stalled while output drains");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import irfc_pkg::*;

    localparam int ITERS      = DEF_TRIG_ITERATIONS;
    localparam int FRAC       = DEF_ANGLE_FRAC_BITS;
    localparam int LATENCY    = ITERS + 6;
    localparam int N_RANDOM   = 2000;
    localparam int CYCLE_CAP  = 400000;
    localparam logic [2:0] ADDR_YAW_OFS   = {REG_YAW_OFFSET, 2'b00};
    localparam logic [2:0] ADDR_PITCH_OFS = {REG_PITCH_OFFSET, 2'b00};

    // arctangent steps in 2^-20 degree, one per rotation
    localparam longint ATAN_STEP [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct packed {
        logic signed [OUT_W-1:0] yaw;
        logic signed [OUT_W-1:0] pitch;
        logic signed [ANG_W-1:0] roll;
    } t_frame;

    // floor shift right of a signed value
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Q1.15 cosine and sine of an angle in 2^-FRAC degree
    task automatic cordic_cos_sin(input longint ang, output longint c, output longint s);
        longint full, half, quarter, z, x, y, nx;
        bit flipped;
        full    = longint'(360) <<< ANG_SHIFT;
        half    = longint'(180) <<< ANG_SHIFT;
        quarter = longint'(90) <<< ANG_SHIFT;
        z = ang * (longint'(1) <<< (ANG_SHIFT - FRAC));
        x = 652032875;
        y = 0;
        flipped = 0;
        z = z % full;
        if (z < 0) z += full;
        if (z > half) z -= full;
        if (z > quarter) begin
            z -= half;
            flipped = 1;
        end else if (z < -quarter) begin
            z += half;
            flipped = 1;
        end
        for (int i = 0; i < ITERS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                y  = y + floor_shr(x, i);
                z -= ATAN_STEP[i];
            end else begin
                nx = x + floor_shr(y, i);
                y  = y - floor_shr(x, i);
                z += ATAN_STEP[i];
            end
            x = nx;
        end
        if (flipped) begin
            x = -x;
            y = -y;
        end
        c = clamp(floor_shr(x + 16384, 15), -32768, 32767);
        s = clamp(floor_shr(y + 16384, 15), -32768, 32767);
    endtask

    // compensate one sample against the current offsets
    task automatic correct_frame(input logic signed [15:0] yaw_in, pitch_in, roll_rate,
                                 input logic signed [14:0] roll_in, pitch_ang,
                                 input longint yaw_ofs, pitch_ofs,
                                 output t_frame f);
        longint yc, pc, rr, roll, pitch, band, half_turn, cp, sp, cr, sr;
        yc = longint'(yaw_in) - yaw_ofs;
        pc = longint'(pitch_in) - pitch_ofs;
        rr = longint'(roll_rate);
        roll  = longint'(roll_in);
        pitch = longint'(pitch_ang);
        band      = longint'(5) <<< FRAC;
        half_turn = longint'(180) <<< FRAC;
        // outside the level band (edges included): flip roll toward zero
        if (!(roll > -band && roll < band))
            roll = roll > 0 ? roll - half_turn : roll + half_turn;
        cordic_cos_sin(pitch, cp, sp);
        cordic_cos_sin(roll, cr, sr);
        f.yaw   = OUT_W'(clamp(floor_shr(yc * cp + rr * sp + 16384, 15), -65536, 65535));
        f.pitch = OUT_W'(clamp(floor_shr(-pc * cr + yc * sr + 16384, 15), -65536, 65535));
        f.roll  = ANG_W'(roll);
    endtask

    class frame_scoreboard;
        t_frame pending[$];
        int     mismatches;

        function void note_sample(t_frame f);
            pending.push_back(f);
        endfunction

        function void check_word(t_frame got);
            t_frame want;
            if (pending.size() == 0) begin
                report(got, got, "unexpected word");
                return;
            end
            want = pending.pop_front();
            if (got.yaw !== want.yaw) report(want, got, "yaw rate");
            if (got.pitch !== want.pitch) report(want, got, "pitch rate");
            if (got.roll !== want.roll) report(want, got, "roll angle");
        endfunction

        function void report(t_frame want, t_frame got, string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d %0d %0d got %0d %0d %0d", what,
                         want.yaw, want.pitch, want.roll, got.yaw, got.pitch, got.roll);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    irfc_in_if  in_ch();
    irfc_out_if out_ch();

    imu_rate_frame_correction u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    frame_scoreboard board = new();
    longint yaw_offset, pitch_offset;
    bit     idle_allowed;      // cleared for the last part of the run
    bit     hold_output;       // long receiver hold-off request
    int     cycles;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // check every word taken from the output
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_word('{out_ch.yaw_rate_out, out_ch.pitch_rate_out,
                               out_ch.roll_angle_out});
    end

    // note every word accepted at the input
    always @(posedge i_clk) begin
        t_frame f;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            correct_frame(in_ch.yaw_rate_in, in_ch.pitch_rate_in, in_ch.roll_rate_in,
                          in_ch.roll_angle_in, in_ch.pitch_angle_in,
                          yaw_offset, pitch_offset, f);
            board.note_sample(f);
        end
    end

    // receiver: random stall bursts, plus a long hold-off when asked
    initial begin
        int burst;
        out_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                out_ch.ready <= 0;
                repeat (60) @(negedge i_clk);
                hold_output = 0;
            end
            if (idle_allowed && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 4);
                out_ch.ready <= 0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1;
            end
        end
    end

    // write one offset register: setup cycle, then access cycle
    task automatic write_offset(input logic [2:0] addr, input logic signed [15:0] value);
        @(negedge i_clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= addr;
        pwdata  <= {{16{value[15]}}, value};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        if (addr == ADDR_YAW_OFS) yaw_offset = longint'(value);
        else pitch_offset = longint'(value);
    endtask

    task automatic write_offsets(input logic signed [15:0] yaw_ofs, pitch_ofs);
        write_offset(ADDR_YAW_OFS, yaw_ofs);
        write_offset(ADDR_PITCH_OFS, pitch_ofs);
    endtask

    // offer one word and hold it until it is taken; valid stays up for the next word
    task automatic send_sample(input logic signed [15:0] yaw, pitch, roll_rate,
                               input logic signed [14:0] roll, pitch_ang);
        if (idle_allowed && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid          <= 1;
        in_ch.yaw_rate_in    <= yaw;
        in_ch.pitch_rate_in  <= pitch;
        in_ch.roll_rate_in   <= roll_rate;
        in_ch.roll_angle_in  <= roll;
        in_ch.pitch_angle_in <= pitch_ang;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // angle mostly in range, sometimes any 15-bit value, sometimes near the band edge
    function automatic logic signed [14:0] pick_angle();
        int sel;
        int edge_ang;
        sel = $urandom_range(0, 9);
        edge_ang = 5 << FRAC;
        if (sel == 0) return 15'($urandom);
        if (sel < 3) return 15'($urandom_range(0, 4) - 2 +
                                ($urandom_range(0, 1) ? edge_ang : -edge_ang));
        return 15'(int'($urandom_range(0, 23040)) - 11520);
    endfunction

    task automatic send_random();
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), pick_angle(), pick_angle());
    endtask

    // drop valid, wait until the pipeline has delivered everything, then let it settle
    task automatic drain();
        in_ch.valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    initial begin
        int band;
        band = 5 << FRAC;
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 0;
        in_ch.yaw_rate_in = '0;
        in_ch.pitch_rate_in = '0;
        in_ch.roll_rate_in = '0;
        in_ch.roll_angle_in = '0;
        in_ch.pitch_angle_in = '0;
        yaw_offset = 0;
        pitch_offset = 0;
        idle_allowed = 1;
        hold_output = 0;
        cycles = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: field extremes, band edges, wrap beyond 180 degrees
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 15'sd0, 15'sd0);
        send_sample(-16'sh8000, -16'sh8000, -16'sh8000, 15'(band), 15'(band));
        send_sample(16'sh7fff, -16'sh8000, 16'sh7fff, 15'(-band), 15'sd5760);
        send_sample(16'sh1234, 16'sh4321, -16'sh0100, 15'(band - 1), -15'sd5760);
        send_sample(-16'sh1234, 16'sh0042, 16'sh0777, 15'(-band + 1), 15'sd11520);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 15'sd11520, -15'sd11520);
        send_sample(-16'sh8000, 16'sh7fff, -16'sh8000, -15'sd11520, 15'sd2880);
        send_sample(16'sd1000, -16'sd1000, 16'sd500, 15'sh3fff, -15'sh4000);
        send_sample(16'sd0, 16'sd0, 16'sd0, -15'sh4000, 15'sh3fff);
        send_sample(16'sd300, 16'sd300, 16'sd300, 15'sd1, -15'sd1);
        drain();

        // extreme offsets drive the rate sums into saturation
        write_offsets(16'sh7fff, -16'sh8000);
        send_sample(-16'sh8000, 16'sh7fff, 16'sh7fff, 15'sd0, 15'sd0);
        send_sample(-16'sh8000, 16'sh7fff, -16'sh8000, 15'sd11520, 15'sd11520);
        send_sample(16'sh7fff, -16'sh8000, 16'sh7fff, 15'sd100, 15'sd2000);
        drain();
        write_offsets(-16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, -16'sh8000, 16'sh7fff, 15'sd0, -15'sd100);
        send_sample(16'sh7fff, -16'sh8000, -16'sh8000, -15'sd11520, 15'sd5760);
        drain();

        // random phases across offset settings; one holds the output for a long stretch
        for (int phase = 0; phase < 8; phase++) begin
            write_offsets(16'($urandom), 16'($urandom));
            if (phase == 2) hold_output = 1;
            if (phase == 7) idle_allowed = 0;
            for (int n = 0; n < N_RANDOM / 8; n++) send_random();
            // pause the sender until every result is back
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/irfc_pkg.sv
rtl/irfc_in_if.sv
rtl/irfc_out_if.sv
rtl/irfc_prep.sv
rtl/irfc_cell.sv
rtl/irfc_post.sv
rtl/imu_rate_frame_correction.sv
sim/tb.sv
